FILE: rtl/core/rrb_pkg.sv
// Shared types and constants of the record ring buffer.
`default_nettype none
package rrb_pkg;
    localparam int unsigned BUFFER_WORDS = 1024;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CNT_W   = 10;
    localparam int unsigned FREED_W = 11;
    localparam int unsigned WORD_W  = 64;
    localparam logic [LEN_W-1:0] MAX_LEN   = 13'd8184;
    localparam logic [CNT_W-1:0] MAX_COUNT = 10'd1023;

    localparam logic [KIND_W-1:0] K_BEGIN_WR = 3'd0;
    localparam logic [KIND_W-1:0] K_WRITE    = 3'd1;
    localparam logic [KIND_W-1:0] K_END_WR   = 3'd2;
    localparam logic [KIND_W-1:0] K_BEGIN_RD = 3'd3;
    localparam logic [KIND_W-1:0] K_READ     = 3'd4;
    localparam logic [KIND_W-1:0] K_END_RD   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NODATA  = 3'd2;
    localparam logic [STAT_W-1:0] ST_CORRUPT = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADSEQ  = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic hdr_rd;     // read header at read pointer
        logic exec;       // perform the item's operation
        logic evict;      // drop oldest record
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic need_hdr;   // item needs header check at read pointer
        logic want_evict; // begin write lacks space, try eviction
        logic evict_ok;   // oldest header is evictable
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/core/rrb_ctrl.sv
// Controller sequencing each item through header fetch, eviction and result.
`default_nettype none
module rrb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire rrb_pkg::t_stat i_stat,
    output rrb_pkg::t_cmd      o_cmd
);
    import rrb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DEC   = 5'b00010,
        S_HDR   = 5'b00100,
        S_CHK   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // fetch the oldest header when the item or an eviction needs it
                if (i_stat.need_hdr || i_stat.want_evict) begin
                    o_cmd.hdr_rd = 1'b1;
                    n_state = S_HDR;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_HDR: n_state = S_CHK;
            S_CHK: begin
                if (i_stat.want_evict && i_stat.evict_ok) begin
                    o_cmd.evict = 1'b1;
                    n_state = S_DEC;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

FILE: rtl/core/rrb_dp.sv
// Datapath: ring memory, pointers, open-record state and result registers.
`default_nettype none
module rrb_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_overwrite,
    input  wire logic [rrb_pkg::KIND_W-1:0] i_kind,
    input  wire logic [rrb_pkg::WORD_W-1:0] i_payload,
    input  wire logic [rrb_pkg::LEN_W-1:0]  i_length,
    input  wire rrb_pkg::t_cmd              i_cmd,
    output rrb_pkg::t_stat                  o_stat,
    output logic [rrb_pkg::STAT_W-1:0]      o_status,
    output logic [rrb_pkg::WORD_W-1:0]      o_payload,
    output logic [rrb_pkg::LEN_W-1:0]       o_rlen,
    output logic [rrb_pkg::CNT_W-1:0]       o_count,
    output logic [rrb_pkg::FREED_W-1:0]     o_freed
);
    import rrb_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_WORDS);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned TW = LEN_W - 2;
    localparam logic [PW-1:0] DEPTH = PW'(BUFFER_WORDS);

    logic [WORD_W-1:0] r_mem [BUFFER_WORDS];
    logic [WORD_W-1:0] r_rdata;

    logic [PW-1:0] r_wp, r_rp, r_hdr, r_wcur, r_rcur;
    logic [LEN_W-1:0] r_wlen, r_rlen_open;
    logic [CNT_W-1:0] r_cnt;
    logic r_wopen, r_ropen;
    logic [KIND_W-1:0] r_kind;
    logic [WORD_W-1:0] r_pay;
    logic [LEN_W-1:0] r_len;

    // words of a record, header included
    function automatic logic [TW-1:0] tot_words(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] s;
        s = {1'b0, len} + (LEN_W+1)'(7);
        return TW'(s[LEN_W:3]) + TW'(1);
    endfunction

    logic [PW-1:0] avail;
    logic [TW-1:0] new_tot, wr_tot, rd_tot, hdr_tot;
    logic          len_bad, corrupt_ptr, no_room;
    logic [PW:0]   room;
    logic [STAT_W-1:0] hdr_st;
    logic [LEN_W-1:0]  hdr_len;

    assign avail   = r_wp - r_rp;
    assign new_tot = tot_words(r_len);
    assign wr_tot  = tot_words(r_wlen);
    assign rd_tot  = tot_words(r_rlen_open);
    assign len_bad = (r_len == '0) || (r_len > MAX_LEN)
                   || ((PW+1)'(new_tot) > (PW+1)'(DEPTH));
    assign corrupt_ptr = avail > DEPTH;
    assign room    = (PW+1)'(DEPTH) - (PW+1)'(avail);
    assign no_room = (PW+1)'(new_tot) > room;
    assign hdr_len = r_rdata[LEN_W-1:0];
    assign hdr_tot = tot_words(hdr_len);

    // judge the header just read at the read pointer
    always_comb begin
        if (avail == '0 || r_rdata == '0) hdr_st = ST_NODATA;
        else if (r_rdata > WORD_W'(MAX_LEN)) hdr_st = ST_CORRUPT;
        else if ((PW+1)'(hdr_tot) > (PW+1)'(avail)) hdr_st = ST_CORRUPT;
        else hdr_st = ST_OK;
    end

    logic bw_check;
    assign bw_check = (r_kind == K_BEGIN_WR) && !r_wopen && !len_bad && !corrupt_ptr;
    assign o_stat.need_hdr = (r_kind == K_BEGIN_RD) && !r_ropen && !corrupt_ptr;
    assign o_stat.want_evict = bw_check && no_room && i_overwrite && !r_ropen
                             && (avail != '0);
    assign o_stat.evict_ok = hdr_st == ST_OK;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [WORD_W-1:0] mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wp[AW-1:0];
        mem_wd = '0;
        mem_ra = i_cmd.hdr_rd ? r_rp[AW-1:0] : r_rcur[AW-1:0];
        if (i_cmd.exec) begin
            case (r_kind)
                K_BEGIN_WR: mem_we = bw_check && !no_room;
                K_WRITE: begin
                    mem_we = r_wopen && ((r_wcur - r_hdr) < PW'(wr_tot));
                    mem_wa = r_wcur[AW-1:0];
                    mem_wd = r_pay;
                end
                K_END_WR: begin
                    mem_we = r_wopen;
                    mem_wa = r_hdr[AW-1:0];
                    mem_wd = WORD_W'(r_wlen);
                end
                default: mem_we = 1'b0;
            endcase
        end
    end

    logic rd_fire;
    assign rd_fire = i_cmd.load && (i_kind == K_READ);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.hdr_rd || rd_fire) r_rdata <= r_mem[mem_ra];
    end

    // capture item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_pay  <= i_payload;
            r_len  <= i_length;
        end
    end

    // execute operation, update state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_hdr <= '0; r_wcur <= '0; r_rcur <= '0;
            r_wlen <= '0; r_rlen_open <= '0; r_cnt <= '0;
            r_wopen <= 1'b0; r_ropen <= 1'b0;
            o_status <= ST_OK; o_payload <= '0; o_rlen <= '0; o_freed <= '0;
        end else begin
            if (i_cmd.evict) begin
                r_rp <= r_rp + PW'(hdr_tot);
                if (r_cnt != '0) r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.exec) begin
                o_status <= ST_OK; o_payload <= '0; o_rlen <= '0; o_freed <= '0;
                case (r_kind)
                    K_BEGIN_WR: begin
                        if (r_wopen || len_bad) o_status <= ST_BADSEQ;
                        else if (corrupt_ptr) o_status <= ST_CORRUPT;
                        else if (no_room) begin
                            if (!i_overwrite || r_ropen || avail == '0)
                                o_status <= ST_NOSPACE;
                            else o_status <= hdr_st;
                        end else begin
                            r_hdr   <= r_wp;
                            r_wlen  <= r_len;
                            r_wcur  <= r_wp + PW'(1);
                            r_wp    <= r_wp + PW'(new_tot);
                            r_wopen <= 1'b1;
                        end
                    end
                    K_WRITE: begin
                        if (!r_wopen || (r_wcur - r_hdr) >= PW'(wr_tot))
                            o_status <= ST_BADSEQ;
                        else r_wcur <= r_wcur + PW'(1);
                    end
                    K_END_WR: begin
                        if (!r_wopen) o_status <= ST_BADSEQ;
                        else begin
                            if (r_cnt != MAX_COUNT) r_cnt <= r_cnt + CNT_W'(1);
                            r_wopen <= 1'b0;
                        end
                    end
                    K_BEGIN_RD: begin
                        if (r_ropen) o_status <= ST_BADSEQ;
                        else if (corrupt_ptr) o_status <= ST_CORRUPT;
                        else if (hdr_st != ST_OK) o_status <= hdr_st;
                        else begin
                            r_rlen_open <= hdr_len;
                            r_rcur  <= r_rp + PW'(1);
                            r_ropen <= 1'b1;
                            o_rlen  <= hdr_len;
                        end
                    end
                    K_READ: begin
                        if (!r_ropen || (r_rcur - r_rp) >= PW'(rd_tot))
                            o_status <= ST_BADSEQ;
                        else begin
                            o_payload <= r_rdata;
                            r_rcur <= r_rcur + PW'(1);
                        end
                    end
                    K_END_RD: begin
                        if (!r_ropen) o_status <= ST_BADSEQ;
                        else begin
                            o_freed <= FREED_W'(rd_tot);
                            r_rp <= r_rp + PW'(rd_tot);
                            if (r_cnt != '0) r_cnt <= r_cnt - CNT_W'(1);
                            r_ropen <= 1'b0;
                        end
                    end
                    default: o_status <= ST_BADSEQ;
                endcase
            end
        end
    end

    assign o_count = r_cnt;
endmodule
`default_nettype wire

FILE: rtl/core/record_ring_buffer_unit.sv
// Top level of the record ring buffer: stream ports, controller and datapath.
`default_nettype none
// Each item gives exactly one result item. Write word, end write, read word
// and end read execute in the decode state and present their result in the
// output state; begin read first passes the header fetch and check states, as
// it reads the oldest header through the single registered memory read port.
// Begin write is like write word, plus decode, header fetch and check for each
// oldest record evicted in overwrite mode, and header fetch and check when
// eviction stops at an uncommitted or corrupt header. The next item is accepted
// in idle once the result is taken. The ring memory is not cleared after reset.
module record_ring_buffer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,     // overwrite_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,    // payload_in[63:0], length_bytes[76:64]
    input  wire logic [2:0]  s_axis_tuser,    // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [103:0]     m_axis_tdata     // status, payload_out, record_length,
                                              // record_count, freed_words
);
    import rrb_pkg::*;

    logic r_overwrite;
    t_cmd  cmd;
    t_stat stat;
    logic [STAT_W-1:0]  status;
    logic [WORD_W-1:0]  pay;
    logic [LEN_W-1:0]   rlen;
    logic [CNT_W-1:0]   cnt;
    logic [FREED_W-1:0] freed;

    // hold overwrite mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_overwrite <= 1'b0;
        else if (i_cfg_we) r_overwrite <= i_cfg_wdata;
    end

    rrb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    rrb_dp u_dp (
        .i_clk, .i_rst_n, .i_overwrite(r_overwrite),
        .i_kind(s_axis_tuser), .i_payload(s_axis_tdata[63:0]),
        .i_length(s_axis_tdata[76:64]), .i_cmd(cmd), .o_stat(stat),
        .o_status(status), .o_payload(pay), .o_rlen(rlen),
        .o_count(cnt), .o_freed(freed)
    );

    assign m_axis_tdata = {3'b000, freed, cnt, rlen, pay, status};

`ifndef SYNTH
    a_exec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.exec && cmd.evict)) else $error("exec and evict together");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> m_axis_tvalid) else $error("no result after exec");
`endif
endmodule
`default_nettype wire

FILE: verif/record_ring_buffer_unit_tb.sv
// Testbench of the record ring buffer: directed and random items checked against a ring model.
`default_nettype none
module record_ring_buffer_unit_tb;
    import rrb_pkg::*;

    localparam int unsigned RING_WORDS = 1024;
    localparam int unsigned PTR_MASK   = 2 * RING_WORDS - 1;
    localparam int unsigned IDX_MASK   = RING_WORDS - 1;
    localparam int unsigned STALL_LIMIT = 40000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned RANDOM_ITEMS = 740;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  payload;
        logic [LEN_W-1:0]   rec_len;
        logic [CNT_W-1:0]   count;
        logic [FREED_W-1:0] freed;
    } t_ring_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic         i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;   // payload_in[63:0], length_bytes[76:64]
    logic [2:0]   s_axis_tuser;   // kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;   // status, payload_out, record_length, record_count, freed_words

    record_ring_buffer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ring model state
    logic [WORD_W-1:0] ring [RING_WORDS];
    bit                ring_written [RING_WORDS];
    int unsigned wr_ptr, rd_ptr, held, wr_hdr, wr_len, wr_cur, rd_cur, rd_len;
    bit          wr_open, rd_open, evict_mode;

    t_ring_result pending_results [$];
    int unsigned  mismatches;
    int unsigned  items_sent;
    bit           quiet;
    bit           hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned record_words(int unsigned len);
        return 1 + ((len + 7) >> 3);
    endfunction

    function automatic int unsigned ring_fill();
        return (wr_ptr - rd_ptr) & PTR_MASK;
    endfunction

    // inspect the header at the read pointer
    function automatic logic [STAT_W-1:0] oldest_header(output int unsigned len,
                                                        output int unsigned tot);
        logic [WORD_W-1:0] hdr;
        int unsigned avail;
        avail = ring_fill();
        len = 0;
        tot = 0;
        if (avail < 1) return ST_NODATA;
        hdr = ring_written[rd_ptr & IDX_MASK] ? ring[rd_ptr & IDX_MASK] : '0;
        if (hdr == 0) return ST_NODATA;
        if (hdr > MAX_LEN) return ST_CORRUPT;
        len = int'(hdr);
        tot = record_words(len);
        if (tot > avail) return ST_CORRUPT;
        return ST_OK;
    endfunction

    // advance the ring model by one item and return its result
    function automatic t_ring_result apply_operation(logic [KIND_W-1:0] kind,
                                                     logic [WORD_W-1:0] word,
                                                     logic [LEN_W-1:0] len);
        t_ring_result r;
        int unsigned tot, l, t;
        r.status = ST_OK;
        r.payload = '0;
        r.rec_len = '0;
        r.freed = '0;
        case (kind)
            K_BEGIN_WR: begin
                if (wr_open || len == 0 || len > MAX_LEN) begin
                    r.status = ST_BADSEQ;
                end else if (record_words(len) > RING_WORDS) begin
                    r.status = ST_BADSEQ;
                end else if (ring_fill() > RING_WORDS) begin
                    r.status = ST_CORRUPT;
                end else begin
                    tot = record_words(len);
                    // evict oldest records until the new one fits
                    while (tot > RING_WORDS - ring_fill()) begin
                        if (!evict_mode || rd_open || ring_fill() < 1) begin
                            r.status = ST_NOSPACE;
                            break;
                        end
                        r.status = oldest_header(l, t);
                        if (r.status != ST_OK) break;
                        rd_ptr = (rd_ptr + t) & PTR_MASK;
                        if (held > 0) held--;
                    end
                    if (r.status == ST_OK) begin
                        ring[wr_ptr & IDX_MASK] = '0;
                        ring_written[wr_ptr & IDX_MASK] = 1'b1;
                        wr_hdr = wr_ptr;
                        wr_len = len;
                        wr_cur = (wr_ptr + 1) & PTR_MASK;
                        wr_ptr = (wr_ptr + tot) & PTR_MASK;
                        wr_open = 1'b1;
                    end
                end
            end
            K_WRITE: begin
                if (!wr_open ||
                    ((wr_cur - wr_hdr) & PTR_MASK) >= record_words(wr_len)) begin
                    r.status = ST_BADSEQ;
                end else begin
                    ring[wr_cur & IDX_MASK] = word;
                    ring_written[wr_cur & IDX_MASK] = 1'b1;
                    wr_cur = (wr_cur + 1) & PTR_MASK;
                end
            end
            K_END_WR: begin
                if (!wr_open) begin
                    r.status = ST_BADSEQ;
                end else begin
                    ring[wr_hdr & IDX_MASK] = WORD_W'(wr_len);
                    if (held < MAX_COUNT) held++;
                    wr_open = 1'b0;
                end
            end
            K_BEGIN_RD: begin
                if (rd_open) begin
                    r.status = ST_BADSEQ;
                end else if (ring_fill() > RING_WORDS) begin
                    r.status = ST_CORRUPT;
                end else begin
                    r.status = oldest_header(l, t);
                    if (r.status == ST_OK) begin
                        rd_len = l;
                        rd_cur = (rd_ptr + 1) & PTR_MASK;
                        rd_open = 1'b1;
                        r.rec_len = LEN_W'(l);
                    end
                end
            end
            K_READ: begin
                if (!rd_open ||
                    ((rd_cur - rd_ptr) & PTR_MASK) >= record_words(rd_len)) begin
                    r.status = ST_BADSEQ;
                end else begin
                    r.payload = ring[rd_cur & IDX_MASK];
                    rd_cur = (rd_cur + 1) & PTR_MASK;
                end
            end
            K_END_RD: begin
                if (!rd_open) begin
                    r.status = ST_BADSEQ;
                end else begin
                    r.freed = FREED_W'(record_words(rd_len));
                    rd_ptr = (rd_ptr + record_words(rd_len)) & PTR_MASK;
                    if (held > 0) held--;
                    rd_open = 1'b0;
                end
            end
            default: r.status = ST_BADSEQ;
        endcase
        r.count = CNT_W'(held);
        return r;
    endfunction

    // true if a read word would return a word never stored
    function automatic bit read_hits_unwritten();
        if (!rd_open) return 1'b0;
        if (((rd_cur - rd_ptr) & PTR_MASK) >= record_words(rd_len)) return 1'b0;
        return !ring_written[rd_cur & IDX_MASK];
    endfunction

    // offer one item after a random gap and record its expected result
    task automatic send_item(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] word,
                             logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, len, word};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results = {pending_results, apply_operation(kind, word, len)};
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_evict_mode(bit mode);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        evict_mode = mode;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // begin a record, store some payload words, optionally commit
    task automatic write_record(int unsigned len, int unsigned nwords, bit commit);
        send_item(K_BEGIN_WR, rand_word(), LEN_W'(len));
        if (!wr_open) return;
        repeat (nwords) send_item(K_WRITE, rand_word(), LEN_W'($urandom));
        if (commit) send_item(K_END_WR, rand_word(), LEN_W'($urandom));
    endtask

    // open the oldest record, fetch some words, optionally release it
    task automatic read_record(int unsigned nwords, bit release_it);
        send_item(K_BEGIN_RD, rand_word(), LEN_W'($urandom));
        if (!rd_open) return;
        repeat (nwords) begin
            if (!read_hits_unwritten()) send_item(K_READ, rand_word(), LEN_W'($urandom));
        end
        if (release_it) send_item(K_END_RD, rand_word(), LEN_W'($urandom));
    endtask

    task automatic test_wrong_sequence();
        send_item(K_WRITE, '1, '1);
        send_item(K_END_WR, '0, '0);
        send_item(K_READ, '0, '0);
        send_item(K_END_RD, '0, '0);
        send_item(K_BEGIN_RD, '0, '0);
    endtask

    task automatic test_length_extremes();
        send_item(K_BEGIN_WR, '0, 13'd0);
        send_item(K_BEGIN_WR, '0, 13'd8185);
        send_item(K_BEGIN_WR, '0, 13'd8191);
        // full-ring record, committed early
        send_item(K_BEGIN_WR, '0, MAX_LEN);
        send_item(K_WRITE, '1, '0);
        send_item(K_WRITE, '0, '1);
        send_item(K_BEGIN_WR, '0, 13'd8);
        send_item(K_END_WR, '0, '0);
        send_item(K_BEGIN_RD, '0, '0);
        send_item(K_BEGIN_RD, '0, '0);
        send_item(K_READ, '0, '0);
        send_item(K_READ, '0, '0);
        send_item(K_END_RD, '0, '0);
        // one-byte record with an extra word past its payload
        write_record(1, 2, 1'b1);
        read_record(2, 1'b1);
    endtask

    task automatic test_space_and_eviction();
        set_evict_mode(1'b0);
        repeat (11) write_record(800, 4, 1'b1);
        set_evict_mode(1'b1);
        // an open read blocks eviction
        read_record(3, 1'b0);
        send_item(K_BEGIN_WR, '0, 13'd800);
        send_item(K_END_RD, '0, '0);
        write_record(4000, 3, 1'b1);
        write_record(8184, 1, 1'b1);
        read_record(1, 1'b1);
        set_evict_mode(1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at, len, n, sel;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            if ((items_sent % 300) < 8 && pending_results.size() == 0)
                set_evict_mode($urandom_range(0, 1));
            quiet = ((items_sent / 200) % 4) == 3;
            sel = $urandom_range(0, 99);
            if (sel < 42) begin
                len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 120) :
                      ($urandom_range(0, 9) < 8) ? $urandom_range(1, 2000) :
                      $urandom_range(7000, 8184);
                n = (len + 7) >> 3;
                if (n > 40) n = $urandom_range(1, 4);
                sel = $urandom_range(0, 9);
                if (sel == 0 && n > 0) n = n - 1;
                else if (sel == 1) n = n + $urandom_range(1, 2);
                write_record(len, n, $urandom_range(0, 19) != 0);
            end else if (sel < 82) begin
                n = $urandom_range(0, 9) < 8 ? 16 : $urandom_range(0, 3);
                read_record(n, $urandom_range(0, 19) != 0);
            end else begin
                sel = $urandom_range(0, 5);
                if (!(sel == K_READ && read_hits_unwritten()))
                    send_item(KIND_W'(sel), rand_word(), LEN_W'($urandom_range(0, 8191)));
            end
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (6) write_record(16, 2, 1'b1);
        repeat (6) read_record(2, 1'b1);
    endtask

    // compare each result with the oldest expectation
    initial begin
        t_ring_result want, got;
        int unsigned stall;
        m_axis_tready = 1'b0;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
            got.status  = m_axis_tdata[2:0];
            got.payload = m_axis_tdata[66:3];
            got.rec_len = m_axis_tdata[79:67];
            got.count   = m_axis_tdata[89:80];
            got.freed   = m_axis_tdata[100:90];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d payload %h", got.status,
                             got.payload);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.payload !== want.payload ||
                    got.rec_len !== want.rec_len || got.count !== want.count ||
                    got.freed !== want.freed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st %0d pay %h len %0d cnt %0d fr %0d,",
                                 want.status, want.payload, want.rec_len, want.count,
                                 want.freed,
                                 " got st %0d pay %h len %0d cnt %0d fr %0d",
                                 got.status, got.payload, got.rec_len,
                                 got.count, got.freed);
                end
            end
        end
    end

    // end the run if nothing moves for too long
    initial begin
        int unsigned idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("record_ring_buffer_unit_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        wr_ptr = 0; rd_ptr = 0; held = 0; wr_hdr = 0; wr_len = 0;
        wr_cur = 0; rd_cur = 0; rd_len = 0;
        wr_open = 1'b0; rd_open = 1'b0; evict_mode = 1'b0;
        mismatches = 0; items_sent = 0; quiet = 1'b0; hold_req = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_wrong_sequence();
        test_length_extremes();
        test_space_and_eviction();
        test_output_backpressure();
        test_random_traffic();
        set_evict_mode(1'b1);
        test_random_traffic();

        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("record_ring_buffer_unit_tb: PASS");
        end else begin
            $display("record_ring_buffer_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
